// File: sv/mpo_pkg.sv
// Package for the multiwave phase oscillator: field widths, register indexes,
// wave mode codes and the digit-serial multiplier constants. No dependencies.
package mpo_pkg;

  localparam int CV_W      = 16;  // control voltage, signed Q15.0
  localparam int GAIN_W    = 32;  // freq_gain register
  localparam int AMP_W     = 15;  // amplitude register, Q0.15
  localparam int MODE_W    = 2;   // wave_mode register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // cv * gain is a 48-bit product; the phase increment is its top bits
  localparam int PROD_W    = CV_W + GAIN_W;

  // digit-serial multiply: one control digit per cycle, LSB first
  localparam int DIGIT_W   = 4;
  localparam int DIGITS    = CV_W / DIGIT_W;
  localparam int CNT_W     = $clog2(DIGITS);

  // pi/2 in Q30, seed of the quarter-wave table
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd2;

  localparam logic [MODE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [MODE_W-1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [MODE_W-1:0] WAVE_SQUARE   = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd89478;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd32767;

endpackage

// File: sv/multiwave_phase_oscillator.sv
// Multiwave phase oscillator top level: digit-serial phase increment,
// phase accumulator, sine ROM, triangle/square shaping and amplitude scale.
// Depends on mpo_pkg.
//
// Usage:
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
//   clock edge (0 wave_mode, 1 freq_gain, 2 amplitude, other indexes are
//   dropped). Write only while no transaction is in flight.
//   Input channel: one control-voltage sample per transaction
//   (in_valid_i/in_ready_o). Output channel: one signed sample per input
//   (out_valid_o/out_ready_i).
//   Path: the result passes through the multiply digits, phase update, wave
//   index, table/shape and scale steps, in that order.
//   Throughput: a new input is taken only after the previous sample has left
//   the scale step, as the 4-bit-per-cycle control-voltage multiplier and the
//   single sequencer walk each sample through the stages.
//   Reset clears phase to zero and loads the register defaults; the sine
//   table is a constant ROM built at elaboration, so no fill pass is needed.
//   Stall: a finished result waits in the output register; the next input is
//   taken meanwhile, and its scale step holds until the output slot frees.
//   Wave mode 3 leaves the phase unchanged and returns zero.
module multiwave_phase_oscillator
  import mpo_pkg::*;
#(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [CV_W-1:0]        control_voltage_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int SHIFT   = PROD_W - PHASE_BITS;
  localparam int FRAC_W  = PHASE_BITS - 2;
  localparam int IW      = $clog2(SINE_TABLE_DEPTH);
  localparam int DW      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MAG_W   = SAMPLE_BITS - 1;
  localparam int TRI_W   = 17;
  localparam int TRIP_W  = TRI_W + MAG_W;
  localparam int SCL_W   = MAG_W + AMP_W;

  localparam logic [MAG_W-1:0]  FS      = '1;
  localparam logic [63:0]       FS64    = 64'(FS);
  localparam logic [63:0]       TWO_D   = 64'(2 * SINE_TABLE_DEPTH);
  localparam logic [DW-1:0]     DEPTH_C = DW'(SINE_TABLE_DEPTH);
  localparam logic [IW-1:0]     IDX_TOP = IW'(SINE_TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PHASE,
    ST_WAVE,
    ST_LOOK,
    ST_SCALE
  } state_e;

  // Quarter-wave entry k: round(FS * sin(pi/2 * (k+1/2)/D)), Q30 series
  function automatic logic [63:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(HALF_PI_Q30) * 64'(2 * k + 1)) / TWO_D;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;   sum = sum - term;
    term = ((term * x2) >> 30) / 20;  sum = sum + term;
    term = ((term * x2) >> 30) / 42;  sum = sum - term;
    term = ((term * x2) >> 30) / 72;  sum = sum + term;
    term = ((term * x2) >> 30) / 110; sum = sum - term;
    term = ((term * x2) >> 30) / 156; sum = sum + term;
    term = ((term * x2) >> 30) / 210; sum = sum - term;
    term = ((term * x2) >> 30) / 272; sum = sum + term;
    term = ((term * x2) >> 30) / 342; sum = sum - term;
    term = ((term * x2) >> 30) / 420; sum = sum + term;
    return (sum * FS64 + (64'd1 << 29)) >> 30;
  endfunction

  logic [MAG_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] ENTRY = sine_entry(g);
    assign sine_rom[g] = ENTRY[MAG_W-1:0];
  end

  // Control and configuration
  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [MODE_W-1:0]     wave_mode_q;
  logic [GAIN_W-1:0]     freq_gain_q;
  logic [AMP_W-1:0]      amplitude_q;
  logic                  out_valid_q;

  // Datapath
  logic [PROD_W-1:0]     acc_q;
  logic [PROD_W-1:0]     gain_sh_q;
  logic [CV_W-1:0]       cv_sh_q;
  logic [IW-1:0]         idx_q;
  logic                  neg_q;
  logic [TRIP_W-1:0]     tri_prod_q;
  logic [MAG_W-1:0]      mag_q;
  logic [SAMPLE_BITS-1:0] sample_q;

  logic                  in_fire;
  logic                  out_free;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;

  // Digit-serial multiply: gain times one control digit, shifted gain
  logic [PROD_W+DIGIT_W-1:0] pp_full;
  logic [PROD_W-1:0]         acc_init;
  logic [PHASE_BITS-1:0]     inc;
  logic [PHASE_BITS-1:0]     phase_d;

  assign pp_full  = gain_sh_q * cv_sh_q[DIGIT_W-1:0];
  // signed cv: take it as unsigned and remove gain * 2^16 when negative
  assign acc_init = control_voltage_i[CV_W-1]
                  ? PROD_W'(0) - {freq_gain_q, {CV_W{1'b0}}}
                  : '0;
  assign inc      = acc_q[SHIFT +: PHASE_BITS];

  always_comb begin
    case (wave_mode_q)
      WAVE_SINE, WAVE_SQUARE: phase_d = phase_q + inc;
      WAVE_TRIANGLE:          phase_d = phase_q + {inc[PHASE_BITS-2:0], 1'b0};
      default:                phase_d = phase_q;
    endcase
  end

  // Wave index and triangle shape from the new phase
  logic [FRAC_W+DW-1:0] frac_prod;
  logic [IW-1:0]        idx_raw;
  logic [15:0]          p16;
  logic [TRI_W-1:0]     tri_d;
  logic [TRI_W+1:0]     tri_4d;
  logic [TRI_W-1:0]     tri_mag;
  logic                 tri_neg;

  assign frac_prod = phase_q[FRAC_W-1:0] * DEPTH_C;
  assign idx_raw   = frac_prod[FRAC_W +: IW];
  assign p16       = phase_q[PHASE_BITS-1 -: 16];
  assign tri_d     = p16[15] ? TRI_W'({1'b0, p16[14:0]})
                             : TRI_W'(17'd32768 - TRI_W'(p16));
  assign tri_4d    = {tri_d, 2'b00};
  assign tri_neg   = !tri_4d[16] && !tri_4d[17] && !tri_4d[18];
  assign tri_mag   = tri_neg ? TRI_W'(19'd65536 - tri_4d) : TRI_W'(tri_4d - 19'd65536);

  logic [TRIP_W-1:0] tri_round;
  logic [SCL_W-1:0]  scl_sum;
  logic [MAG_W-1:0]  scl_mag;
  logic [SAMPLE_BITS-1:0] sample_d;

  assign tri_round = tri_prod_q + TRIP_W'(32768);
  assign scl_sum   = mag_q * amplitude_q + SCL_W'(16384);
  assign scl_mag   = scl_sum[AMP_W +: MAG_W];

  always_comb begin
    case (wave_mode_q)
      WAVE_SINE, WAVE_TRIANGLE, WAVE_SQUARE:
        sample_d = neg_q ? SAMPLE_BITS'(0) - {1'b0, scl_mag} : {1'b0, scl_mag};
      default: sample_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      phase_q     <= '0;
      wave_mode_q <= WAVE_SINE;
      freq_gain_q <= GAIN_RESET;
      amplitude_q <= AMP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WAVE_MODE: wave_mode_q <= cfg_data_i[MODE_W-1:0];
          CFG_FREQ_GAIN: freq_gain_q <= cfg_data_i[GAIN_W-1:0];
          CFG_AMPLITUDE: amplitude_q <= cfg_data_i[AMP_W-1:0];
          default: ;
        endcase
      end
      // raise valid as a finished sample lands, drop it once it is taken
      if (state_q == ST_SCALE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIGITS - 1)) begin
            state_q <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          phase_q <= phase_d;
          state_q <= ST_WAVE;
        end
        ST_WAVE:  state_q <= ST_LOOK;
        ST_LOOK:  state_q <= ST_SCALE;
        ST_SCALE: begin
          // hold until the output slot is free
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          acc_q     <= acc_init;
          gain_sh_q <= PROD_W'(freq_gain_q);
          cv_sh_q   <= control_voltage_i;
        end
      end
      ST_MUL: begin
        acc_q     <= acc_q + pp_full[PROD_W-1:0];
        gain_sh_q <= gain_sh_q << DIGIT_W;
        cv_sh_q   <= cv_sh_q >> DIGIT_W;
      end
      ST_WAVE: begin
        idx_q      <= phase_q[PHASE_BITS-2] ? IDX_TOP - idx_raw : idx_raw;
        tri_prod_q <= tri_mag * FS;
        case (wave_mode_q)
          WAVE_TRIANGLE: neg_q <= tri_neg;
          default:       neg_q <= phase_q[PHASE_BITS-1];
        endcase
      end
      ST_LOOK: begin
        case (wave_mode_q)
          WAVE_SINE:     mag_q <= sine_rom[idx_q];
          WAVE_TRIANGLE: mag_q <= tri_round[16 +: MAG_W];
          default:       mag_q <= FS;
        endcase
      end
      ST_SCALE: begin
        if (out_free) begin
          sample_q <= sample_d;
        end
      end
      default: ;
    endcase
  end

  // An accepted sample always starts the multiply
  a_fire_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MUL && cnt_q == '0))
    else $error("accepted sample did not start the multiply");

  // Phase moves only in the phase update step
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_PHASE) |=> $stable(phase_q))
    else $error("phase changed outside the update step");

  // A finished sample lands in a free output slot
  a_scale_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE && out_free) |=> (out_valid_o && in_ready_o))
    else $error("finished sample not presented");

  // The phase update follows directly on the last multiply digit
  a_mul_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PHASE) |-> ($past(state_q) == ST_MUL
                               && $past(cnt_q) == CNT_W'(DIGITS - 1)))
    else $error("multiply length wrong");

endmodule
